@@ src/gia_pkg.sv @@
package gia_pkg;

    localparam int SLOTS  = 1024;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int VER_W  = 8;
    localparam int KIND_W = 3;
    localparam int STAT_W = 2;
    localparam int HIDX_W = 24;
    localparam int HVER_W = 8;

    localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DESTROY = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EXISTS  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DEL_ALL = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEANUP = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_CLOSED  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_IDX = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_QRY,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0] addr;
        logic             link_en;
        logic [IDX_W-1:0] link;
        logic             ver_en;
        logic [VER_W-1:0] ver;
    } t_wr_req;

    typedef struct packed {
        logic [IDX_W-1:0] link;
        logic [VER_W-1:0] ver;
    } t_rd_rsp;

endpackage

@@ src/generational_id_allocator_core.sv @@
// Generational slot allocator: hands out handles of (slot index, version).
// Command channel: present i_kind/i_id_index/i_id_version with start high;
// the word is taken at a rising edge where start is high and busy is low.
// Result channel: o_valid pulses for one cycle with o_status, o_new_index,
// o_new_version and o_found; it cannot be held off by the receiver.
// Where the result word is registered:
//   at accept: destroy, grow-create, full/closed/bad-index answers, cleanup
//   in POP/QRY: create from the free list, exists on a non-zero in-range index
//   destroy-all: at the end of the walk (one table entry per cycle)
// Back-to-back: busy stays low after a command answered at accept, so the next
// word can follow at once; other commands hold busy until their o_valid cycle.
// The slot table is one synchronous 1024-deep memory pair (link, version)
// with one read and one write port and registered read data; every
// read-modify-write goes through it, so the block takes one command at a
// time and holds busy high while a table read is outstanding. The walk
// overlaps the read of the next entry with the write-back of the current.
// Reset (i_rst_n low, synchronous) reopens the block with free head 1 and
// used count 1 (slot 0 reserved); the table is not cleared, as no entry is
// read before a create has written it. Cleanup closes the block until the
// next reset; after it create, destroy, exists and destroy-all answer "closed".
module generational_id_allocator_core
    import gia_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [HIDX_W-1:0] i_id_index,
    input  logic [HVER_W-1:0] i_id_version,
    output logic              o_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [IDX_W-1:0]  o_new_index,
    output logic [HVER_W-1:0] o_new_version,
    output logic              o_found
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_free, n_free;       // free-list head
    logic [CNT_W-1:0]  r_used, n_used;       // high-water count
    logic              r_closed, n_closed;
    logic [IDX_W-1:0]  r_ptr, n_ptr;         // slot under work
    logic [HVER_W-1:0] r_qver, n_qver;       // version of an exists query
    logic              r_valid, n_valid;
    logic [STAT_W-1:0] r_status, n_status;
    logic [IDX_W-1:0]  r_nidx, n_nidx;
    logic [HVER_W-1:0] r_nver, n_nver;
    logic              r_found, n_found;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    t_rd_rsp           rd_rsp;
    t_wr_req           wr_req;

    logic              idx_oob;
    logic [IDX_W-1:0]  in_idx;
    logic [CNT_W-1:0]  nxt_ptr;
    logic [VER_W-1:0]  bumped_ver;
    logic [IDX_W-1:0]  push_link;

    gia_table u_table (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_rsp  (rd_rsp),
        .i_wr_req  (wr_req)
    );

    assign idx_oob    = i_id_index >= HIDX_W'(r_used);
    assign in_idx     = i_id_index[IDX_W-1:0];
    assign nxt_ptr    = CNT_W'(r_ptr) + CNT_W'(1);
    assign bumped_ver = rd_rsp.ver + VER_W'(1);
    // push onto the free list: a head at the high-water mark means "empty"
    assign push_link  = (r_free == r_used) ? IDX_W'(0) : r_free[IDX_W-1:0];

    always_comb begin
        n_state  = r_state;
        n_free   = r_free;
        n_used   = r_used;
        n_closed = r_closed;
        n_ptr    = r_ptr;
        n_qver   = r_qver;
        n_valid  = 1'b0;
        n_status = STAT_OK;
        n_nidx   = '0;
        n_nver   = '0;
        n_found  = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_req   = '0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (r_closed && i_kind <= KIND_DEL_ALL) begin
                        n_valid  = 1'b1;
                        n_status = STAT_CLOSED;
                    end else begin
                        case (i_kind)
                            KIND_CREATE: begin
                                if (r_free >= r_used) begin
                                    if (r_used >= CNT_W'(SLOTS)) begin
                                        n_valid  = 1'b1;
                                        n_status = STAT_FULL;
                                    end else begin
                                        // grow: fresh slot starts at version 1
                                        wr_req.addr    = r_used[IDX_W-1:0];
                                        wr_req.link_en = 1'b1;
                                        wr_req.link    = r_used[IDX_W-1:0];
                                        wr_req.ver_en  = 1'b1;
                                        wr_req.ver     = VER_W'(1);
                                        n_used  = r_used + CNT_W'(1);
                                        n_free  = r_used + CNT_W'(1);
                                        n_valid = 1'b1;
                                        n_nidx  = r_used[IDX_W-1:0];
                                        n_nver  = HVER_W'(1);
                                    end
                                end else begin
                                    rd_en   = 1'b1;
                                    rd_addr = r_free[IDX_W-1:0];
                                    n_ptr   = r_free[IDX_W-1:0];
                                    n_state = ST_POP;
                                end
                            end
                            KIND_DESTROY: begin
                                n_valid = 1'b1;
                                if (i_id_index == '0 || idx_oob) begin
                                    n_status = STAT_BAD_IDX;
                                end else begin
                                    wr_req.addr    = in_idx;
                                    wr_req.link_en = 1'b1;
                                    wr_req.link    = push_link;
                                    n_free         = CNT_W'(in_idx);
                                end
                            end
                            KIND_EXISTS: begin
                                if (idx_oob) begin
                                    n_valid  = 1'b1;
                                    n_status = STAT_BAD_IDX;
                                end else if (i_id_index == '0) begin
                                    n_valid = 1'b1;
                                end else begin
                                    rd_en   = 1'b1;
                                    rd_addr = in_idx;
                                    n_ptr   = in_idx;
                                    n_qver  = i_id_version;
                                    n_state = ST_QRY;
                                end
                            end
                            KIND_DEL_ALL: begin
                                if (r_used > CNT_W'(1)) begin
                                    rd_en   = 1'b1;
                                    rd_addr = IDX_W'(1);
                                    n_ptr   = IDX_W'(1);
                                    n_state = ST_WALK;
                                end else begin
                                    n_valid = 1'b1;
                                end
                            end
                            KIND_CLEANUP: begin
                                n_used   = '0;
                                n_free   = '0;
                                n_closed = 1'b1;
                                n_valid  = 1'b1;
                            end
                            default: begin
                                n_valid = 1'b1;
                            end
                        endcase
                    end
                end
            end
            ST_POP: begin
                // a zero or stale link ends the list: next create grows
                if (rd_rsp.link == '0 || CNT_W'(rd_rsp.link) >= r_used) begin
                    n_free = r_used;
                end else begin
                    n_free = CNT_W'(rd_rsp.link);
                end
                wr_req.addr    = r_ptr;
                wr_req.link_en = 1'b1;
                wr_req.link    = r_ptr;
                wr_req.ver_en  = 1'b1;
                wr_req.ver     = bumped_ver;
                n_valid        = 1'b1;
                n_nidx         = r_ptr;
                n_nver         = HVER_W'(bumped_ver);
                n_state        = ST_IDLE;
            end
            ST_QRY: begin
                n_valid = 1'b1;
                n_found = (rd_rsp.link == r_ptr) && (rd_rsp.ver == VER_W'(r_qver));
                n_state = ST_IDLE;
            end
            ST_WALK: begin
                // entry r_ptr is in rd_rsp; read of r_ptr+1 overlaps its write
                if (rd_rsp.link == r_ptr) begin
                    wr_req.addr    = r_ptr;
                    wr_req.link_en = 1'b1;
                    wr_req.link    = push_link;
                    n_free         = CNT_W'(r_ptr);
                end
                if (nxt_ptr < r_used) begin
                    rd_en   = 1'b1;
                    rd_addr = nxt_ptr[IDX_W-1:0];
                    n_ptr   = nxt_ptr[IDX_W-1:0];
                end else begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_free   <= CNT_W'(1);
            r_used   <= CNT_W'(1);
            r_closed <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_free   <= n_free;
            r_used   <= n_used;
            r_closed <= n_closed;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_qver   <= n_qver;
        r_status <= n_status;
        r_nidx   <= n_nidx;
        r_nver   <= n_nver;
        r_found  <= n_found;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_new_index   = r_nidx;
    assign o_new_version = r_nver;
    assign o_found       = r_found;

endmodule

@@ src/gia_table.sv @@
module gia_table
    import gia_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_rd_rsp          o_rd_rsp,
    input  t_wr_req          i_wr_req
);

    logic [IDX_W-1:0] r_link_mem [SLOTS];
    logic [VER_W-1:0] r_ver_mem  [SLOTS];
    t_rd_rsp          r_rsp;

    always_ff @(posedge i_clk) begin
        if (i_wr_req.link_en) begin
            r_link_mem[i_wr_req.addr] <= i_wr_req.link;
        end
        if (i_wr_req.ver_en) begin
            r_ver_mem[i_wr_req.addr] <= i_wr_req.ver;
        end
        if (i_rd_en) begin
            r_rsp.link <= r_link_mem[i_rd_addr];
            r_rsp.ver  <= r_ver_mem[i_rd_addr];
        end
    end

    assign o_rd_rsp = r_rsp;

endmodule

@@ src/gia_checker.sv @@
module gia_checker
    import gia_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [KIND_W-1:0] i_kind,
    input  logic              o_valid,
    input  logic [STAT_W-1:0] o_status,
    input  logic [IDX_W-1:0]  o_new_index,
    input  logic [HVER_W-1:0] o_new_version,
    input  logic              o_found
);

    // result word only appears once the table is free again
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result while busy");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_valid)
        else $error("not quiet after reset");

    a_cleanup_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_kind == KIND_CLEANUP |=> o_valid && o_status == STAT_OK)
        else $error("cleanup must answer ok next cycle");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STAT_OK |->
            o_new_index == '0 && o_new_version == '0 && !o_found)
        else $error("error word carries data");

    a_found_only_exists: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_new_index == '0 && o_new_version == '0)
        else $error("found with create data");

endmodule

bind generational_id_allocator_core gia_checker u_gia_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_kind        (i_kind),
    .o_valid       (o_valid),
    .o_status      (o_status),
    .o_new_index   (o_new_index),
    .o_new_version (o_new_version),
    .o_found       (o_found)
);
